[design/csb_pkg.sv]
package csb_pkg;

   localparam int SCREEN_WIDTH    = 320;
   localparam int SCREEN_HEIGHT   = 240;
   localparam int SPRITE_SIDE_MAX = 255;

   localparam int COLOUR_W = 16;
   localparam int ADDR_W   = 32;
   localparam int COUNT_W  = 8;
   localparam int ORIGIN_W = 11;
   localparam int POS_W    = ORIGIN_W + 1;
   localparam int SIDE_W   = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ROW_SHIFT  = 10;

   localparam logic [COLOUR_W-1:0] KEY_COLOUR = 16'h0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ORIGIN_X      = 3'd0,
      REG_ORIGIN_Y      = 3'd1,
      REG_SPRITE_WIDTH  = 3'd2,
      REG_SPRITE_HEIGHT = 3'd3,
      REG_FRAME_BASE    = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]   write_address;
      logic [COLOUR_W-1:0] write_colour;
   } result_type;

endpackage

[design/csb_req_if.sv]
interface csb_req_if;
   import csb_pkg::*;

   logic                valid;
   logic                ready;
   logic [COLOUR_W-1:0] pixel_colour;

   modport source (output valid, output pixel_colour, input ready);
   modport sink   (input valid, input pixel_colour, output ready);
endinterface

[design/csb_rsp_if.sv]
interface csb_rsp_if;
   import csb_pkg::*;

   logic                valid;
   logic                ready;
   logic [ADDR_W-1:0]   write_address;
   logic [COLOUR_W-1:0] write_colour;

   modport source (output valid, output write_address, output write_colour, input ready);
   modport sink   (input valid, input write_address, input write_colour, output ready);
endinterface

[design/csb_result_buf.sv]
module csb_result_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  csb_pkg::result_type  push_data,
   output logic                 has_room,
   output logic                 out_valid,
   input  logic                 out_ready,
   output csb_pkg::result_type  out_data
);
   import csb_pkg::*;

   result_type  entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        pop;

   assign out_valid = (count_ff != 2'd0);
   assign has_room  = (count_ff != 2'd2);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/clipped_sprite_blitter_unit.sv]
// a drawn pixel is registered in the result queue and shows on rsp_chan when it reaches the queue head
// throughput: one request per cycle while the result queue has room, set by the combinational clip and address logic
// a two-entry result queue keeps requests flowing while one result waits to be taken
// clipped and transparent pixels advance the counters and produce no result
// reset (synchronous, active high) clears counters and queue, registers to defaults
module clipped_sprite_blitter_unit (
   input  logic                             clock,
   input  logic                             reset,
   csb_req_if.sink                          req_chan,
   csb_rsp_if.source                        rsp_chan,
   input  logic                             csr_write_enable,
   input  logic [csb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [csb_pkg::CSR_DATA_W-1:0]   csr_data
);
   import csb_pkg::*;

   logic [ORIGIN_W-1:0] origin_x_ff, origin_y_ff;
   logic [COUNT_W-1:0]  sprite_width_ff, sprite_height_ff;
   logic [ADDR_W-1:0]   frame_base_ff;
   logic [COUNT_W-1:0]  column_count_ff, column_count_in;
   logic [COUNT_W-1:0]  row_count_ff, row_count_in;

   logic [SIDE_W-1:0]   eff_width, eff_height;
   logic [POS_W-1:0]    x_pos, y_pos;
   logic                on_screen, accept, push, has_room;
   logic                row_end, sprite_end;
   result_type          result, out_data;

   localparam logic [SIDE_W-1:0] SideMax = SIDE_W'(SPRITE_SIDE_MAX);
   localparam logic [POS_W-1:0]  ScrW    = POS_W'(SCREEN_WIDTH);
   localparam logic [POS_W-1:0]  ScrH    = POS_W'(SCREEN_HEIGHT);

   assign req_chan.ready = has_room;
   assign accept = req_chan.valid && has_room;

   always_comb begin
      eff_width  = ({2'b00, sprite_width_ff}  > SideMax) ? SideMax : {2'b00, sprite_width_ff};
      eff_height = ({2'b00, sprite_height_ff} > SideMax) ? SideMax : {2'b00, sprite_height_ff};

      x_pos = {origin_x_ff[ORIGIN_W-1], origin_x_ff} + POS_W'(column_count_ff);
      y_pos = {origin_y_ff[ORIGIN_W-1], origin_y_ff} + POS_W'(row_count_ff);
      on_screen = !x_pos[POS_W-1] && (x_pos < ScrW) && !y_pos[POS_W-1] && (y_pos < ScrH);

      result.write_address = frame_base_ff
                           + (ADDR_W'(y_pos[POS_W-2:0]) << ROW_SHIFT)
                           + (ADDR_W'(x_pos[POS_W-2:0]) << 1);
      result.write_colour  = req_chan.pixel_colour;
      push = accept && on_screen && (req_chan.pixel_colour != KEY_COLOUR);

      // zero sizes behave as one, since count + 1 is always >= 0
      row_end    = (SIDE_W'(column_count_ff) + SIDE_W'(1)) >= eff_width;
      sprite_end = (SIDE_W'(row_count_ff) + SIDE_W'(1)) >= eff_height;

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (row_end) begin
            column_count_in = '0;
            row_count_in    = sprite_end ? '0 : row_count_ff + COUNT_W'(1);
         end else begin
            column_count_in = column_count_ff + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= '0;
         origin_y_ff      <= '0;
         sprite_width_ff  <= COUNT_W'(48);
         sprite_height_ff <= COUNT_W'(48);
         frame_base_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_ORIGIN_X:      origin_x_ff      <= csr_data[ORIGIN_W-1:0];
            REG_ORIGIN_Y:      origin_y_ff      <= csr_data[ORIGIN_W-1:0];
            REG_SPRITE_WIDTH:  sprite_width_ff  <= csr_data[COUNT_W-1:0];
            REG_SPRITE_HEIGHT: sprite_height_ff <= csr_data[COUNT_W-1:0];
            REG_FRAME_BASE:    frame_base_ff    <= csr_data[ADDR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   csb_result_buf u_result_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .has_room  (has_room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (out_data)
   );

   assign rsp_chan.write_address = out_data.write_address;
   assign rsp_chan.write_colour  = out_data.write_colour;

endmodule

[design/csb_checker.sv]
module csb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic [csb_pkg::COLOUR_W-1:0]  req_pixel_colour,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [csb_pkg::ADDR_W-1:0]    rsp_write_address,
   input logic [csb_pkg::COLOUR_W-1:0]  rsp_write_colour
);
   import csb_pkg::*;

   // stalled response keeps valid and payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_write_address)
                                  && $stable(rsp_write_colour))
      else $error("stalled response dropped or changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_no_key_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_write_colour != KEY_COLOUR)
      else $error("transparent colour written");

   // a transparent request into an empty queue produces nothing
   a_key_silent: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_pixel_colour == KEY_COLOUR) && !rsp_valid
      |=> !rsp_valid)
      else $error("response from transparent request");

endmodule

bind clipped_sprite_blitter_unit csb_checker u_csb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .req_pixel_colour  (req_chan.pixel_colour),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_write_address (rsp_chan.write_address),
   .rsp_write_colour  (rsp_chan.write_colour)
);
